// ----- hw/rtl/apscr_pkg.sv -----
// Shared types, constants and lookup functions for the autobaud printable scorer.
package apscr_pkg;

    localparam int BAUD_W   = 22;
    localparam int SCORE_W  = 18;
    localparam int CNT_W    = 10;
    localparam int NUM_CANDS = 8;
    localparam int IDX_W    = 3;

    // Per-window byte cap (16..1023, must fit CNT_W).
    localparam logic [CNT_W-1:0] BYTE_CAP  = 10'd512;
    localparam logic [CNT_W-1:0] MIN_BYTES = 10'd16;
    localparam logic [CNT_W-1:0] FULL_BYTES = 10'd256;

    localparam logic [BAUD_W-1:0]  DEFAULT_BAUD   = 22'd115200;
    localparam logic [SCORE_W-1:0] SCORE_MINUS_ONE = 18'h30000;

    // Request kinds carried in tuser.
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    typedef logic [BAUD_W-1:0] t_baud;

    function automatic t_baud cand_baud(input logic [IDX_W-1:0] idx);
        t_baud b;
        case (idx)
            3'd0:    b = 22'd115200;
            3'd1:    b = 22'd57600;
            3'd2:    b = 22'd38400;
            3'd3:    b = 22'd19200;
            3'd4:    b = 22'd9600;
            3'd5:    b = 22'd230400;
            3'd6:    b = 22'd460800;
            default: b = 22'd921600;
        endcase
        return b;
    endfunction

    // CR, LF, TAB, or 0x20..0x7E.
    function automatic logic is_printable(input logic [7:0] v);
        return (v == 8'h0D) || (v == 8'h0A) || (v == 8'h09) ||
               ((v >= 8'h20) && (v <= 8'h7E));
    endfunction

endpackage

// ----- hw/rtl/autobaud_printable_scorer.sv -----
// Autobaud scorer: counts window bytes, scores each candidate baud, picks the best.
//
// A start request (tuser = 2) restarts the scan and immediately offers the
// first candidate baud, 115200. Byte requests (tuser = 0, byte in tdata) are
// counted as they arrive: total, zero bytes and printable bytes (CR, LF, TAB,
// 0x20..0x7E); bytes past the per-window cap are dropped. A window-end
// request (tuser = 1) scores the window in Q16 as
// (printable*min(total,256) - 64*zeros)*256/total, truncated toward zero, or
// -1.0 if fewer than 16 bytes arrived, keeps the strictly best score and
// offers the next candidate; after the eighth window tlast is set and tdata
// carries the chosen baud (the fallback baud, latched at start, if no window
// beat -1.0). Start and byte requests are handled as they are accepted. A
// window end with at least 16 bytes goes through the count product on the
// multiplier, the signed numerator, the shared shift-subtract divider (one
// quotient bit per cycle) and a final step that updates the best score and
// loads the output register once it is free. A short window goes straight
// to the final step. The input side stalls while the sequencer is busy, and
// while an unread result sits in the output register. Byte, window-end or
// unused requests outside a scan are dropped without a result. Fallback baud
// writes are taken every cycle and apply at the next start; zero means 115200.
module autobaud_printable_scorer
    import apscr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Fallback baud write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [BAUD_W-1:0]         i_cfg_data,
    // Request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]                s_axis_tuser,   // [1:0] req_type
    // Result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [BAUD_W+SCORE_W-1:0] m_axis_tdata,   // [21:0] set_baud, [39:22] window_score
    output logic                      m_axis_tlast    // scan_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam int DVD_W = 26;   // 18-bit numerator magnitude, times 256
    localparam int MAG_W = 18;
    localparam int PROD_W = 19;
    localparam logic [4:0] DIV_LAST = 5'd25;

    logic [2:0]          r_state, n_state;
    logic [BAUD_W-1:0]   r_fallback;
    logic                r_scanning;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_total, r_print, r_zero;
    logic signed [SCORE_W-1:0] r_best;
    logic [BAUD_W-1:0]   r_best_baud;

    // Score datapath
    logic [PROD_W-1:0]   r_prod;
    logic                r_neg;
    logic [CNT_W-1:0]    r_rem;
    logic [DVD_W-1:0]    r_dvd;
    logic [4:0]          r_cnt;
    logic signed [SCORE_W-1:0] r_score;

    // Output register
    logic                r_out_valid;
    logic [BAUD_W-1:0]   r_out_baud;
    logic [SCORE_W-1:0]  r_out_score;
    logic                r_out_done;

    logic                w_out_free;
    logic                w_accept;
    logic [8:0]          w_m;
    logic signed [PROD_W:0] w_diff;
    logic [PROD_W:0]     w_abs;
    logic [CNT_W:0]      w_trial;
    logic                w_ge;
    logic [CNT_W:0]      w_sub;
    logic [SCORE_W-1:0]  w_q;
    logic                w_better;
    logic [BAUD_W-1:0]   w_best_baud;
    logic                w_last;

    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_score, r_out_baud};
    assign m_axis_tlast  = r_out_done;

    // Window weight min(total,256)
    assign w_m = (r_total < FULL_BYTES) ? r_total[8:0] : 9'd256;

    // Signed numerator (before the *256) and its magnitude
    assign w_diff = $signed({1'b0, r_prod}) -
                    $signed({{(PROD_W-CNT_W-5){1'b0}}, r_zero, 6'b0});
    assign w_abs  = w_diff[PROD_W] ? (PROD_W+1)'(0) - w_diff : w_diff;

    // One restoring-division step
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_total};
    assign w_sub   = w_trial - {1'b0, r_total};

    // Quotient including the bit decided in the current step
    assign w_q = {r_dvd[SCORE_W-2:0], w_ge};

    assign w_better    = r_score > r_best;
    assign w_best_baud = w_better ? cand_baud(r_idx) : r_best_baud;
    assign w_last      = (r_idx == IDX_W'(NUM_CANDS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && r_scanning && (s_axis_tuser == REQ_END)) begin
                    n_state = (r_total < MIN_BYTES) ? S_FIN : S_MUL;
                end
            end
            S_MUL:  n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fallback  <= DEFAULT_BAUD;
            r_scanning  <= 1'b0;
            r_idx       <= '0;
            r_total     <= '0;
            r_print     <= '0;
            r_zero      <= '0;
            r_best      <= SCORE_MINUS_ONE;
            r_best_baud <= DEFAULT_BAUD;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_fallback <= i_cfg_data;
            end

            // load on start or window result, else drain on handshake
            if ((w_accept && (s_axis_tuser == REQ_START)) ||
                ((r_state == S_FIN) && w_out_free)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                if (s_axis_tuser == REQ_START) begin
                    r_scanning  <= 1'b1;
                    r_idx       <= '0;
                    r_total     <= '0;
                    r_print     <= '0;
                    r_zero      <= '0;
                    r_best      <= SCORE_MINUS_ONE;
                    r_best_baud <= (r_fallback == '0) ? DEFAULT_BAUD : r_fallback;
                    r_out_baud  <= cand_baud('0);
                    r_out_score <= '0;
                    r_out_done  <= 1'b0;
                end else if (r_scanning && (s_axis_tuser == REQ_BYTE)) begin
                    if (r_total < BYTE_CAP) begin
                        r_total <= r_total + 1'b1;
                        if (s_axis_tdata == 8'h00) begin
                            r_zero <= r_zero + 1'b1;
                        end
                        if (is_printable(s_axis_tdata)) begin
                            r_print <= r_print + 1'b1;
                        end
                    end
                end
            end

            if ((r_state == S_FIN) && w_out_free) begin
                if (w_better) begin
                    r_best <= r_score;
                end
                r_best_baud <= w_best_baud;
                r_total     <= '0;
                r_print     <= '0;
                r_zero      <= '0;
                r_out_score <= r_score;
                if (w_last) begin
                    r_scanning <= 1'b0;
                    r_idx      <= '0;
                    r_out_baud <= w_best_baud;
                    r_out_done <= 1'b1;
                end else begin
                    r_idx      <= r_idx + 1'b1;
                    r_out_baud <= cand_baud(r_idx + 1'b1);
                    r_out_done <= 1'b0;
                end
            end
        end
    end

    // Score datapath: multiplier, numerator, shared shift-subtract divider
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // short window scores -1.0 without the divider
                if (w_accept && r_scanning && (s_axis_tuser == REQ_END)) begin
                    r_score <= SCORE_MINUS_ONE;
                end
            end
            S_MUL: begin
                r_prod <= PROD_W'(r_print * w_m);
            end
            S_PREP: begin
                r_neg <= w_diff[PROD_W];
                r_dvd <= {w_abs[MAG_W-1:0], 8'b0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_sub[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_score <= r_neg ? -$signed(w_q) : $signed(w_q);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer only takes requests when idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE))
        else $error("request taken while sequencer busy");

    // Counters never pass the cap and subsets never pass the total
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total <= BYTE_CAP) && (r_print <= r_total) && (r_zero <= r_total))
        else $error("window counters inconsistent");

    // Final selection ends the scan
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && w_out_free && w_last |=> !r_scanning && m_axis_tlast)
        else $error("final result without scan end");

    // Outside a scan a window end must not start scoring
    a_no_score_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_scanning && (r_state == S_IDLE) |=> (r_state == S_IDLE))
        else $error("scoring started outside a scan");

endmodule
